>>> rtl/core/nq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_pkg - shared definitions for the fixed-queen N-queens solver
// Board geometry, microcode control word layout, datapath operation codes,
// branch condition codes and the status/control bundles between units.
// ----------------------------------------------------------------------------
package nq_pkg;

    // Board geometry
    localparam int BOARD_SIZE = 8;
    localparam int MAX_SIDE   = 8;
    localparam int SIDE       = (BOARD_SIZE < MAX_SIDE) ? BOARD_SIZE : MAX_SIDE;
    localparam int CW         = 3;            // column / row field width
    localparam int DW         = 4;            // depth, trial row, result counter
    localparam int DIAGS      = 2 * SIDE - 1; // diagonals in each direction
    localparam int GW         = 4;            // diagonal index width

    typedef logic [CW-1:0] t_pos;
    typedef logic [DW-1:0] t_cnt;

    // Microcode address space
    localparam int AW = 4;
    typedef logic [AW-1:0] t_addr;

    localparam t_addr A_IDLE      = 4'd0;
    localparam t_addr A_CHK_BOARD = 4'd1;
    localparam t_addr A_FIX       = 4'd2;
    localparam t_addr A_CHK_DEPTH = 4'd3;
    localparam t_addr A_TEST_END  = 4'd4;
    localparam t_addr A_TEST_FREE = 4'd5;
    localparam t_addr A_BACK      = 4'd6;
    localparam t_addr A_UNMARK    = 4'd7;
    localparam t_addr A_EMIT_CHK  = 4'd8;
    localparam t_addr A_EMIT_ROW  = 4'd9;
    localparam t_addr A_EMIT_NONE = 4'd10;

    // Datapath operations
    typedef logic [3:0] t_op;

    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;  // take request, clear search state
    localparam t_op OP_FIX       = 4'd2;  // place the preset queen
    localparam t_op OP_PLACE     = 4'd3;  // place trial row, go one column deeper
    localparam t_op OP_NEXT_ROW  = 4'd4;  // advance trial row
    localparam t_op OP_DEC_DEPTH = 4'd5;  // step back one column
    localparam t_op OP_UNMARK    = 4'd6;  // lift queen, resume one row below it
    localparam t_op OP_EMIT_ROW  = 4'd7;  // load one found result beat
    localparam t_op OP_EMIT_NONE = 4'd8;  // load the not-found beat

    // Branch conditions
    typedef logic [3:0] t_cond;

    localparam t_cond C_ALWAYS     = 4'd0;
    localparam t_cond C_IN_VALID   = 4'd1;
    localparam t_cond C_OFF_BOARD  = 4'd2;
    localparam t_cond C_DEPTH_FULL = 4'd3;
    localparam t_cond C_TRY_END    = 4'd4;
    localparam t_cond C_CELL_FREE  = 4'd5;
    localparam t_cond C_DEPTH_ZERO = 4'd6;
    localparam t_cond C_OUT_FREE   = 4'd7;
    localparam t_cond C_EMIT_END   = 4'd8;

    // One control word: test a condition, run op_t and go to jmp_t when it
    // holds, else run op_f and go to jmp_f.
    typedef struct packed {
        t_cond cond;
        t_op   op_t;
        t_addr jmp_t;
        t_op   op_f;
        t_addr jmp_f;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic off_board;
        logic depth_full;
        logic try_end;
        logic cell_free;
        logic depth_zero;
        logic out_free;
        logic emit_end;
    } t_status;

    // Sequencer commands to the datapath
    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctrl;

endpackage

>>> rtl/core/nq_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_ifs - request and result channels of the N-queens solver
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface nq_in_if
    import nq_pkg::*;
();
    logic valid;
    logic ready;
    t_pos fixed_column;
    t_pos fixed_row;

    modport source (output valid, output fixed_column, output fixed_row, input ready);
    modport sink   (input valid, input fixed_column, input fixed_row, output ready);
endinterface

interface nq_out_if
    import nq_pkg::*;
();
    logic valid;
    logic ready;
    t_pos column_index;
    t_pos queen_row;
    logic found;
    logic last;

    modport source (output valid, output column_index, output queen_row,
                    output found, output last, input ready);
    modport sink   (input valid, input column_index, input queen_row,
                    input found, input last, output ready);
endinterface

>>> rtl/core/nq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_seq - microcode sequencer
// Step counter over a small control store; each word tests one condition (a
// datapath flag, or always), issues an operation and picks the next step.
// ----------------------------------------------------------------------------
module nq_seq
    import nq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    // Control store
    function automatic t_uword ucode(input t_addr a);
        t_uword w;
        w = '{cond: C_ALWAYS, op_t: OP_NONE, jmp_t: A_IDLE, op_f: OP_NONE, jmp_f: A_IDLE};
        case (a)
            A_IDLE:      w = '{C_IN_VALID,   OP_LOAD,      A_CHK_BOARD,
                               OP_NONE,      A_IDLE};
            A_CHK_BOARD: w = '{C_OFF_BOARD,  OP_NONE,      A_EMIT_NONE,
                               OP_NONE,      A_FIX};
            A_FIX:       w = '{C_ALWAYS,     OP_FIX,       A_CHK_DEPTH,
                               OP_NONE,      A_CHK_DEPTH};
            A_CHK_DEPTH: w = '{C_DEPTH_FULL, OP_NONE,      A_EMIT_CHK,
                               OP_NONE,      A_TEST_END};
            A_TEST_END:  w = '{C_TRY_END,    OP_NONE,      A_BACK,
                               OP_NONE,      A_TEST_FREE};
            A_TEST_FREE: w = '{C_CELL_FREE,  OP_PLACE,     A_CHK_DEPTH,
                               OP_NEXT_ROW,  A_TEST_END};
            A_BACK:      w = '{C_DEPTH_ZERO, OP_NONE,      A_EMIT_NONE,
                               OP_DEC_DEPTH, A_UNMARK};
            A_UNMARK:    w = '{C_ALWAYS,     OP_UNMARK,    A_TEST_END,
                               OP_NONE,      A_TEST_END};
            A_EMIT_CHK:  w = '{C_EMIT_END,   OP_NONE,      A_IDLE,
                               OP_NONE,      A_EMIT_ROW};
            A_EMIT_ROW:  w = '{C_OUT_FREE,   OP_EMIT_ROW,  A_EMIT_CHK,
                               OP_NONE,      A_EMIT_ROW};
            A_EMIT_NONE: w = '{C_OUT_FREE,   OP_EMIT_NONE, A_IDLE,
                               OP_NONE,      A_EMIT_NONE};
            default:     w = '{C_ALWAYS,     OP_NONE,      A_IDLE,
                               OP_NONE,      A_IDLE};
        endcase
        return w;
    endfunction

    t_addr  r_upc;
    t_addr  n_upc;
    t_uword word;
    logic   hit;

    assign word = ucode(r_upc);

    // Condition select
    always_comb begin
        unique case (word.cond)
            C_ALWAYS:     hit = 1'b1;
            C_IN_VALID:   hit = i_status.in_valid;
            C_OFF_BOARD:  hit = i_status.off_board;
            C_DEPTH_FULL: hit = i_status.depth_full;
            C_TRY_END:    hit = i_status.try_end;
            C_CELL_FREE:  hit = i_status.cell_free;
            C_DEPTH_ZERO: hit = i_status.depth_zero;
            C_OUT_FREE:   hit = i_status.out_free;
            C_EMIT_END:   hit = i_status.emit_end;
            default:      hit = 1'b0;
        endcase
    end

    // Branch and issue
    always_comb begin
        n_upc           = hit ? word.jmp_t : word.jmp_f;
        o_ctrl.op       = hit ? word.op_t : word.op_f;
        o_ctrl.in_ready = (r_upc == A_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

>>> rtl/core/nq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_dp - search datapath
// Queen rows per column, row and diagonal occupancy masks, depth and trial
// row counters, and the registered result stage.
// ----------------------------------------------------------------------------
module nq_dp
    import nq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctrl           i_ctrl,
    output t_status         o_status,
    nq_in_if.sink           i_in,
    nq_out_if.source        o_out
);

    // Search state
    t_pos               r_fc, n_fc;
    t_pos               r_fr, n_fr;
    t_pos               r_row [SIDE];
    logic [SIDE-1:0]    r_rows, n_rows;
    logic [DIAGS-1:0]   r_rise, n_rise;
    logic [DIAGS-1:0]   r_fall, n_fall;
    t_cnt               r_depth, n_depth;
    t_cnt               r_try, n_try;
    t_cnt               r_oc, n_oc;

    // Result stage
    logic               r_ov, n_ov;
    t_pos               r_ocol, n_ocol;
    t_pos               r_orow, n_orow;
    logic               r_ofound, n_ofound;
    logic               r_olast, n_olast;

    t_pos               col;
    t_pos               rd_addr;
    t_pos               rd_row;
    t_pos               try_row;
    logic [GW-1:0]      t_rise_idx, t_fall_idx;
    t_pos               m_row, m_col;
    logic [GW-1:0]      m_rise_idx, m_fall_idx;
    logic               row_we;
    t_pos               row_wa, row_wd;

    // Column at the current depth, wrapping round after the preset column
    assign col     = CW'((DW'(r_fc) + DW'(1) + r_depth) % DW'(SIDE));
    assign try_row = r_try[CW-1:0];

    // Single read port of the row store
    assign rd_addr = (i_ctrl.op == OP_EMIT_ROW) ? r_oc[CW-1:0] : col;
    assign rd_row  = r_row[rd_addr];

    // Trial cell diagonals
    assign t_rise_idx = GW'(try_row) + GW'(col);
    assign t_fall_idx = GW'(try_row) + GW'(SIDE - 1) - GW'(col);

    // Cell being marked or cleared
    always_comb begin
        m_row = try_row;
        m_col = col;
        if (i_ctrl.op == OP_FIX) begin
            m_row = r_fr;
            m_col = r_fc;
        end else if (i_ctrl.op == OP_UNMARK) begin
            m_row = rd_row;
        end
    end
    assign m_rise_idx = GW'(m_row) + GW'(m_col);
    assign m_fall_idx = GW'(m_row) + GW'(SIDE - 1) - GW'(m_col);

    // Flags for the sequencer
    always_comb begin
        o_status.in_valid   = i_in.valid;
        o_status.off_board  = (DW'(r_fc) >= DW'(SIDE)) || (DW'(r_fr) >= DW'(SIDE));
        o_status.depth_full = (r_depth == DW'(SIDE - 1));
        o_status.try_end    = (r_try == DW'(SIDE));
        o_status.cell_free  = !r_rows[try_row] && !r_rise[t_rise_idx] && !r_fall[t_fall_idx];
        o_status.depth_zero = (r_depth == '0);
        o_status.out_free   = !r_ov || o_out.ready;
        o_status.emit_end   = (r_oc == DW'(SIDE));
    end

    assign i_in.ready = i_ctrl.in_ready;

    // Operation decode
    always_comb begin
        n_fc     = r_fc;
        n_fr     = r_fr;
        n_rows   = r_rows;
        n_rise   = r_rise;
        n_fall   = r_fall;
        n_depth  = r_depth;
        n_try    = r_try;
        n_oc     = r_oc;
        n_ov     = r_ov && !o_out.ready;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        n_ofound = r_ofound;
        n_olast  = r_olast;
        row_we   = 1'b0;
        row_wa   = col;
        row_wd   = try_row;
        unique case (i_ctrl.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                n_fc    = i_in.fixed_column;
                n_fr    = i_in.fixed_row;
                n_rows  = '0;
                n_rise  = '0;
                n_fall  = '0;
                n_depth = '0;
                n_try   = '0;
                n_oc    = '0;
            end
            OP_FIX: begin
                row_we               = 1'b1;
                row_wa               = r_fc;
                row_wd               = r_fr;
                n_rows[m_row]        = 1'b1;
                n_rise[m_rise_idx]   = 1'b1;
                n_fall[m_fall_idx]   = 1'b1;
            end
            OP_PLACE: begin
                row_we               = 1'b1;
                n_rows[m_row]        = 1'b1;
                n_rise[m_rise_idx]   = 1'b1;
                n_fall[m_fall_idx]   = 1'b1;
                n_depth              = r_depth + DW'(1);
                n_try                = '0;
            end
            OP_NEXT_ROW: begin
                n_try = r_try + DW'(1);
            end
            OP_DEC_DEPTH: begin
                n_depth = r_depth - DW'(1);
            end
            OP_UNMARK: begin
                n_rows[m_row]        = 1'b0;
                n_rise[m_rise_idx]   = 1'b0;
                n_fall[m_fall_idx]   = 1'b0;
                n_try                = DW'(rd_row) + DW'(1);
            end
            OP_EMIT_ROW: begin
                n_ov     = 1'b1;
                n_ocol   = r_oc[CW-1:0];
                n_orow   = rd_row;
                n_ofound = 1'b1;
                n_olast  = (r_oc == DW'(SIDE - 1));
                n_oc     = r_oc + DW'(1);
            end
            OP_EMIT_NONE: begin
                n_ov     = 1'b1;
                n_ocol   = '0;
                n_orow   = '0;
                n_ofound = 1'b0;
                n_olast  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fc     <= n_fc;
        r_fr     <= n_fr;
        r_rows   <= n_rows;
        r_rise   <= n_rise;
        r_fall   <= n_fall;
        r_depth  <= n_depth;
        r_try    <= n_try;
        r_oc     <= n_oc;
        r_ocol   <= n_ocol;
        r_orow   <= n_orow;
        r_ofound <= n_ofound;
        r_olast  <= n_olast;
        if (row_we) begin
            r_row[row_wa] <= row_wd;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.column_index = r_ocol;
    assign o_out.queen_row    = r_orow;
    assign o_out.found        = r_ofound;
    assign o_out.last         = r_olast;

endmodule

>>> rtl/core/n_queens_fixed_queen_solver.sv
`timescale 1ns / 1ps
// Flow: a request is loaded, checked against the board and its queen placed before
//   the search, in which each trial row is tested, then placed or skipped, and backtracks unmark.
// Throughput: one request at a time; a new request is taken once the last
//   result beat is loaded; found result beats are loaded in turn, each waiting for a free result register.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and
//   empties the result register; search state is rebuilt by every request.
// ----------------------------------------------------------------------------
// n_queens_fixed_queen_solver - N-queens search around one preset queen
// Microcoded depth-first search; emits each column's row in column order, or one not-found beat.
// ----------------------------------------------------------------------------
module n_queens_fixed_queen_solver
    import nq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    nq_in_if.sink    i_in,
    nq_out_if.source o_out
);

    t_ctrl   ctrl;
    t_status status;

    // Sequencer
    nq_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // Datapath
    nq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

    // Checks
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while search running");

    a_beat_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.found || o_out.last))
        else $error("not-found beat without last");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found && o_out.last) |-> (o_out.column_index == CW'(SIDE - 1)))
        else $error("found run ends on wrong column");

endmodule
